FILE: rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types and constants of the partitioned byte cache.
// ----------------------------------------------------------------------------
`default_nettype none

package pbc_pkg;

  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 36;
  localparam int SID_W   = 3;
  localparam int HINT_W  = 16;
  localparam int PC_W    = 3;
  localparam int MODE_W  = 2;
  localparam int CNT_W   = 32;
  localparam int EV_W    = 9;
  localparam int HENT_W  = 7;
  localparam int HOME_W  = 4;
  localparam int CADDR_W = 2;

  typedef enum logic [CADDR_W-1:0] {
    CFG_CAPACITY   = 2'd0,
    CFG_PART_COUNT = 2'd1,
    CFG_MODE       = 2'd2,
    CFG_PAGE_FILL  = 2'd3
  } cfg_reg_e;

  localparam logic [MODE_W-1:0] MODE_LRU = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MRU = 2'd2;

  typedef struct packed {
    logic [PC_W-1:0]   part_n;
    logic [MODE_W-1:0] mode;
    logic              fill_en;
  } pbc_cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] cap;
    logic [SID_W-1:0]  sid;
    logic [HOME_W-1:0] home;
  } pbc_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } pbc_entry_t;

endpackage

`default_nettype wire

FILE: rtl/pbc_ram.sv
// ----------------------------------------------------------------------------
// pbc_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/pbc_front.sv
// ----------------------------------------------------------------------------
// pbc_front
// Accepts items, divides capacity and size by the partition count and
// reduces the hint to a home partition, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_front import pbc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [KEY_W-1:0]  tag_key_i,
  input  wire logic        [SIZE_W-1:0] size_bytes_i,
  input  wire logic        [SID_W-1:0]  stream_id_i,
  input  wire logic signed [HINT_W-1:0] partition_hint_i,
  input  wire logic        [SIZE_W-1:0] capacity_i,
  input  wire pbc_cfg_t                 cfg_i,
  output logic                          item_valid_o,
  input  wire logic                     item_ready_i,
  output pbc_item_t                     item_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  localparam logic [5:0] LAST_STEP = 6'(SIZE_W - 1);

  front_state_e state_q, state_d;
  logic [5:0]        step_q, step_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [SID_W-1:0]  sid_q, sid_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic              neg_q, neg_d;
  logic [SIZE_W-1:0] cap_dv_q, cap_dv_d, size_dv_q, size_dv_d, hint_dv_q, hint_dv_d;
  logic [PC_W-1:0]   cap_r_q, cap_r_d, size_r_q, size_r_d, hint_r_q, hint_r_d;
  logic [HINT_W:0]   hint_x, hint_mag;
  logic [PC_W-1:0]   home_w;

  function automatic logic [PC_W+SIZE_W-1:0] div_step(logic [SIZE_W-1:0] dv,
                                                      logic [PC_W-1:0] rem,
                                                      logic [PC_W-1:0] n);
    logic [PC_W:0] r;
    logic          q;
    r = {rem, dv[SIZE_W-1]};
    q = (r >= {1'b0, n});
    if (q) begin
      r = r - {1'b0, n};
    end
    return {r[PC_W-1:0], dv[SIZE_W-2:0], q};
  endfunction

  assign hint_x   = {partition_hint_i[HINT_W-1], partition_hint_i};
  assign hint_mag = partition_hint_i[HINT_W-1] ? ((HINT_W+1)'(0) - hint_x) : hint_x;

  always_comb begin
    if (hint_r_q == '0) begin
      home_w = '0;
    end else if (neg_q) begin
      home_w = cfg_i.part_n - hint_r_q;
    end else begin
      home_w = hint_r_q;
    end
  end

  assign in_ready_o        = (state_q == F_IDLE);
  assign item_valid_o      = (state_q == F_PUSH);
  assign item_o.key        = key_q;
  assign item_o.size       = cfg_i.fill_en ? size_dv_q : size_q;
  assign item_o.cap        = cap_dv_q;
  assign item_o.sid        = sid_q;
  assign item_o.home       = HOME_W'(home_w);

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    key_d     = key_q;
    sid_d     = sid_q;
    size_d    = size_q;
    neg_d     = neg_q;
    cap_dv_d  = cap_dv_q;
    size_dv_d = size_dv_q;
    hint_dv_d = hint_dv_q;
    cap_r_d   = cap_r_q;
    size_r_d  = size_r_q;
    hint_r_d  = hint_r_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          key_d     = tag_key_i;
          sid_d     = stream_id_i;
          size_d    = size_bytes_i;
          neg_d     = partition_hint_i[HINT_W-1];
          cap_dv_d  = capacity_i;
          size_dv_d = size_bytes_i;
          hint_dv_d = SIZE_W'(hint_mag);
          cap_r_d   = '0;
          size_r_d  = '0;
          hint_r_d  = '0;
          step_d    = '0;
          state_d   = F_DIV;
        end
      end
      F_DIV: begin
        {cap_r_d, cap_dv_d}   = div_step(cap_dv_q, cap_r_q, cfg_i.part_n);
        {size_r_d, size_dv_d} = div_step(size_dv_q, size_r_q, cfg_i.part_n);
        {hint_r_d, hint_dv_d} = div_step(hint_dv_q, hint_r_q, cfg_i.part_n);
        step_d = step_q + 6'd1;
        if (step_q == LAST_STEP) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (item_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    sid_q     <= sid_d;
    size_q    <= size_d;
    neg_q     <= neg_d;
    cap_dv_q  <= cap_dv_d;
    size_dv_q <= size_dv_d;
    hint_dv_q <= hint_dv_d;
    cap_r_q   <= cap_r_d;
    size_r_q  <= size_r_d;
    hint_r_q  <= hint_r_d;
  end

endmodule

`default_nettype wire

FILE: rtl/pbc_queue.sv
// ----------------------------------------------------------------------------
// pbc_queue
// Two-entry item queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_queue import pbc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire pbc_item_t push_item_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output pbc_item_t      pop_item_o
);

  pbc_item_t  mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pbc_back.sv
// ----------------------------------------------------------------------------
// pbc_back
// Executes accesses: searches a partition's entry ring, reorders on LRU hits,
// evicts and inserts, keeps counters and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_back import pbc_pkg::*; #(
  parameter int PARTITIONS = 4,
  parameter int ENTRIES    = 64,
  parameter int STREAMS    = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pbc_cfg_t           cfg_i,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  input  wire pbc_item_t          item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    hit_o,
  output logic [SID_W-1:0]        stream_out_o,
  output logic [CNT_W-1:0]        stream_accesses_o,
  output logic [CNT_W-1:0]        stream_misses_o,
  output logic [EV_W-1:0]         evicted_now_o,
  output logic [HENT_W-1:0]       home_entries_o,
  output logic [SIZE_W-1:0]       home_used_bytes_o,
  output logic [CNT_W-1:0]        home_evictions_o
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int PW    = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int PCW   = $clog2(PARTITIONS + 1);
  localparam int SW    = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int DEPTH = PARTITIONS * ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $bits(pbc_entry_t);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SRCH = 9'b000000010,
    S_CMP  = 9'b000000100,
    S_MVRD = 9'b000001000,
    S_MVWR = 9'b000010000,
    S_FIT  = 9'b000100000,
    S_EVW  = 9'b001000000,
    S_NEXT = 9'b010000000,
    S_STEP = 9'b100000000
  } back_state_e;

  back_state_e state_q, state_d;
  logic        done_q, done_d;
  pbc_item_t   item_q, item_d;
  logic [PCW-1:0]    p_q, p_d;
  logic [CW-1:0]     i_q, i_d, k_q, k_d;
  logic [SIZE_W-1:0] hsize_q, hsize_d;
  logic              hit_q, hit_d, ahit_q, ahit_d, fill_q, fill_d, evnew_q, evnew_d;
  logic [EV_W-1:0]   ev_q, ev_d;

  logic [CW-1:0]     cnt_q  [PARTITIONS];
  logic [CW-1:0]     cnt_d  [PARTITIONS];
  logic [IW-1:0]     head_q [PARTITIONS];
  logic [IW-1:0]     head_d [PARTITIONS];
  logic [SIZE_W-1:0] used_q [PARTITIONS];
  logic [SIZE_W-1:0] used_d [PARTITIONS];
  logic [CNT_W-1:0]  evt_q  [PARTITIONS];
  logic [CNT_W-1:0]  evt_d  [PARTITIONS];
  logic [CNT_W-1:0]  acc_q  [STREAMS];
  logic [CNT_W-1:0]  acc_d  [STREAMS];
  logic [CNT_W-1:0]  mis_q  [STREAMS];
  logic [CNT_W-1:0]  mis_d  [STREAMS];

  logic              out_valid_q, out_valid_d;
  logic              o_hit_q, o_hit_d;
  logic [SID_W-1:0]  o_sid_q, o_sid_d;
  logic [CNT_W-1:0]  o_acc_q, o_acc_d, o_mis_q, o_mis_d, o_evt_q, o_evt_d;
  logic [EV_W-1:0]   o_ev_q, o_ev_d;
  logic [HENT_W-1:0] o_ent_q, o_ent_d;
  logic [SIZE_W-1:0] o_used_q, o_used_d;

  logic [PW-1:0]     pi, home;
  logic [SW-1:0]     st, st_in;
  logic [CW-1:0]     cur_cnt, log_idx;
  logic [IW-1:0]     cur_head;
  logic [SIZE_W-1:0] cur_used;
  logic [IW:0]       phys_sum, phys;
  logic [AW-1:0]     ram_addr;
  logic              ram_we;
  pbc_entry_t        ram_wdata, rd;
  logic [EW-1:0]     ram_rdata;
  logic              need_evict, size_fits, table_full, evict_mru, out_free;

  function automatic logic [SW-1:0] stream_of(logic [SID_W-1:0] sid);
    logic [6:0] v;
    v = 7'(sid);
    for (int k = 0; k < 8; k++) begin
      if (32'(v) >= STREAMS) begin
        v = v - 7'(STREAMS);
      end
    end
    return SW'(v);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  assign pi       = p_q[PW-1:0];
  assign home     = item_q.home[PW-1:0];
  assign st       = stream_of(item_q.sid);
  assign st_in    = stream_of(item_i.sid);
  assign cur_cnt  = cnt_q[pi];
  assign cur_head = head_q[pi];
  assign cur_used = used_q[pi];
  assign rd       = pbc_entry_t'(ram_rdata);
  assign evict_mru = (cfg_i.mode == MODE_MRU);

  assign need_evict = (({1'b0, cur_used} + {1'b0, item_q.size}) > {1'b0, item_q.cap})
                      && (cur_cnt != '0);
  assign size_fits  = (item_q.size <= item_q.cap);
  assign table_full = (32'(cur_cnt) >= ENTRIES);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    case (state_q)
      S_MVRD:  log_idx = (k_q == cur_cnt) ? cur_cnt - CW'(1) : k_q;
      S_MVWR:  log_idx = k_q - CW'(1);
      S_FIT: begin
        if (need_evict || (size_fits && table_full)) begin
          log_idx = evict_mru ? cur_cnt - CW'(1) : '0;
        end else begin
          log_idx = cur_cnt;
        end
      end
      default: log_idx = i_q;
    endcase
    phys_sum = (IW+1)'(cur_head) + (IW+1)'(log_idx[IW-1:0]);
    phys     = (32'(phys_sum) >= ENTRIES) ? phys_sum - (IW+1)'(ENTRIES) : phys_sum;
    ram_addr = AW'(int'(pi) * ENTRIES) + AW'(phys);
  end

  pbc_ram #(
    .W (EW),
    .D (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    item_d  = item_q;
    p_d     = p_q;
    i_d     = i_q;
    k_d     = k_q;
    hsize_d = hsize_q;
    hit_d   = hit_q;
    ahit_d  = ahit_q;
    fill_d  = fill_q;
    evnew_d = evnew_q;
    ev_d    = ev_q;
    cnt_d   = cnt_q;
    head_d  = head_q;
    used_d  = used_q;
    evt_d   = evt_q;
    acc_d   = acc_q;
    mis_d   = mis_q;
    ram_we    = 1'b0;
    ram_wdata = '{key: item_q.key, size: item_q.size};
    item_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i && !done_q) begin
          item_ready_o = 1'b1;
          item_d       = item_i;
          acc_d[st_in] = sat_inc(acc_q[st_in]);
          p_d          = PCW'(item_i.home[PW-1:0]);
          i_d          = '0;
          fill_d       = 1'b0;
          ev_d         = '0;
          hit_d        = 1'b0;
          ahit_d       = 1'b0;
          state_d      = S_SRCH;
        end
      end
      S_SRCH: begin
        state_d = (i_q == cur_cnt) ? S_FIT : S_CMP;
      end
      S_CMP: begin
        if (rd.key == item_q.key) begin
          hsize_d = rd.size;
          ahit_d  = 1'b1;
          if (cfg_i.mode == MODE_LRU) begin
            k_d     = i_q + CW'(1);
            state_d = S_MVRD;
          end else begin
            state_d = S_NEXT;
          end
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_SRCH;
        end
      end
      S_MVRD: begin
        if (k_q == cur_cnt) begin
          ram_we    = 1'b1;
          ram_wdata = '{key: item_q.key, size: hsize_q};
          state_d   = S_NEXT;
        end else begin
          state_d = S_MVWR;
        end
      end
      S_MVWR: begin
        ram_we    = 1'b1;
        ram_wdata = rd;
        k_d       = k_q + CW'(1);
        state_d   = S_MVRD;
      end
      S_FIT: begin
        ahit_d = 1'b0;
        if (need_evict || (size_fits && table_full)) begin
          evnew_d = evict_mru;
          state_d = S_EVW;
        end else if (size_fits) begin
          ram_we     = 1'b1;
          cnt_d[pi]  = cur_cnt + CW'(1);
          used_d[pi] = cur_used + item_q.size;
          state_d    = S_NEXT;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_EVW: begin
        used_d[pi] = cur_used - rd.size;
        cnt_d[pi]  = cur_cnt - CW'(1);
        if (!evnew_q) begin
          head_d[pi] = (32'(cur_head) == ENTRIES - 1) ? '0 : cur_head + IW'(1);
        end
        evt_d[pi] = sat_inc(evt_q[pi]);
        if (ev_q != '1) begin
          ev_d = ev_q + EV_W'(1);
        end
        state_d = S_FIT;
      end
      S_NEXT: begin
        if (!fill_q) begin
          hit_d = ahit_q;
          if (ahit_q) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            mis_d[st] = sat_inc(mis_q[st]);
            if (cfg_i.fill_en) begin
              fill_d  = 1'b1;
              p_d     = '0;
              state_d = S_STEP;
            end else begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
        end else begin
          p_d     = p_q + PCW'(1);
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (32'(p_q) >= 32'(cfg_i.part_n)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (pi == home) begin
          p_d = p_q + PCW'(1);
        end else begin
          i_d     = '0;
          state_d = S_SRCH;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // result hand-off; done_q holds the back until the output register frees
    if (done_q && !out_free) begin
      done_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    o_hit_d  = o_hit_q;
    o_sid_d  = o_sid_q;
    o_acc_d  = o_acc_q;
    o_mis_d  = o_mis_q;
    o_ev_d   = o_ev_q;
    o_ent_d  = o_ent_q;
    o_used_d = o_used_q;
    o_evt_d  = o_evt_q;
    if (done_q && out_free) begin
      out_valid_d = 1'b1;
      o_hit_d  = hit_q;
      o_sid_d  = item_q.sid;
      o_acc_d  = acc_q[st];
      o_mis_d  = mis_q[st];
      o_ev_d   = ev_q;
      o_ent_d  = HENT_W'(cnt_q[home]);
      o_used_d = used_q[home];
      o_evt_d  = evt_q[home];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < PARTITIONS; j++) begin
        cnt_q[j]  <= '0;
        head_q[j] <= '0;
        used_q[j] <= '0;
        evt_q[j]  <= '0;
      end
      for (int j = 0; j < STREAMS; j++) begin
        acc_q[j] <= '0;
        mis_q[j] <= '0;
      end
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      used_q      <= used_d;
      evt_q       <= evt_d;
      acc_q       <= acc_d;
      mis_q       <= mis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    p_q      <= p_d;
    i_q      <= i_d;
    k_q      <= k_d;
    hsize_q  <= hsize_d;
    hit_q    <= hit_d;
    ahit_q   <= ahit_d;
    fill_q   <= fill_d;
    evnew_q  <= evnew_d;
    ev_q     <= ev_d;
    o_hit_q  <= o_hit_d;
    o_sid_q  <= o_sid_d;
    o_acc_q  <= o_acc_d;
    o_mis_q  <= o_mis_d;
    o_ev_q   <= o_ev_d;
    o_ent_q  <= o_ent_d;
    o_used_q <= o_used_d;
    o_evt_q  <= o_evt_d;
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = o_hit_q;
  assign stream_out_o      = o_sid_q;
  assign stream_accesses_o = o_acc_q;
  assign stream_misses_o   = o_mis_q;
  assign evicted_now_o     = o_ev_q;
  assign home_entries_o    = o_ent_q;
  assign home_used_bytes_o = o_used_q;
  assign home_evictions_o  = o_evt_q;

endmodule

`default_nettype wire

FILE: rtl/partitioned_byte_cache_sim.sv
// ----------------------------------------------------------------------------
// partitioned_byte_cache_sim
// Partitioned variable-size cache with FIFO, LRU and MRU replacement.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   tag_key, size_bytes, stream_id,
//                                                  partition_hint
//   out      output     out_valid_o / out_ready_i hit .. home_evictions
//   cfg      input      cfg_we_i (no wait)        cfg_addr_i, cfg_wdata_i
//
// Front: one item at a time, divided bit-serially by the partition count
// (36 steps). Back: read and compare per entry searched, read and write per
// entry moved on an LRU hit, fit and evict per eviction, next/step per partition.
// A two-entry queue lets the front work on the next item while the back runs.
// No clearing pass after reset; the back is freed once the result register takes its result.
// ----------------------------------------------------------------------------
`default_nettype none

module partitioned_byte_cache_sim import pbc_pkg::*; #(
  parameter int PARTITIONS = 4,
  parameter int ENTRIES    = 64,
  parameter int STREAMS    = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic        [CADDR_W-1:0] cfg_addr_i,
  input  wire logic        [SIZE_W-1:0] cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [KEY_W-1:0]  tag_key_i,
  input  wire logic        [SIZE_W-1:0] size_bytes_i,
  input  wire logic        [SID_W-1:0]  stream_id_i,
  input  wire logic signed [HINT_W-1:0] partition_hint_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          hit_o,
  output logic             [SID_W-1:0]  stream_out_o,
  output logic             [CNT_W-1:0]  stream_accesses_o,
  output logic             [CNT_W-1:0]  stream_misses_o,
  output logic             [EV_W-1:0]   evicted_now_o,
  output logic             [HENT_W-1:0] home_entries_o,
  output logic             [SIZE_W-1:0] home_used_bytes_o,
  output logic             [CNT_W-1:0]  home_evictions_o
);

  logic [SIZE_W-1:0] cap_q, cap_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic              pf_q, pf_d;
  pbc_cfg_t          cfg;
  logic              q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  pbc_item_t         q_in_item, q_out_item;

  always_comb begin
    cap_d  = cap_q;
    pc_d   = pc_q;
    mode_d = mode_q;
    pf_d   = pf_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_CAPACITY:   cap_d  = cfg_wdata_i;
        CFG_PART_COUNT: pc_d   = cfg_wdata_i[PC_W-1:0];
        CFG_MODE:       mode_d = cfg_wdata_i[MODE_W-1:0];
        CFG_PAGE_FILL:  pf_d   = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= '0;
      pc_q   <= PC_W'(1);
      mode_q <= '0;
      pf_q   <= 1'b0;
    end else begin
      cap_q  <= cap_d;
      pc_q   <= pc_d;
      mode_q <= mode_d;
      pf_q   <= pf_d;
    end
  end

  always_comb begin
    if (pc_q == '0) begin
      cfg.part_n = PC_W'(1);
    end else if (32'(pc_q) > PARTITIONS) begin
      cfg.part_n = PC_W'(PARTITIONS);
    end else begin
      cfg.part_n = pc_q;
    end
    cfg.mode    = mode_q;
    cfg.fill_en = pf_q;
  end

  pbc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .tag_key_i        (tag_key_i),
    .size_bytes_i     (size_bytes_i),
    .stream_id_i      (stream_id_i),
    .partition_hint_i (partition_hint_i),
    .capacity_i       (cap_q),
    .cfg_i            (cfg),
    .item_valid_o     (q_in_valid),
    .item_ready_i     (q_in_ready),
    .item_o           (q_in_item)
  );

  pbc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_in_valid),
    .push_ready_o (q_in_ready),
    .push_item_i  (q_in_item),
    .pop_valid_o  (q_out_valid),
    .pop_ready_i  (q_out_ready),
    .pop_item_o   (q_out_item)
  );

  pbc_back #(
    .PARTITIONS (PARTITIONS),
    .ENTRIES    (ENTRIES),
    .STREAMS    (STREAMS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .item_valid_i      (q_out_valid),
    .item_ready_o      (q_out_ready),
    .item_i            (q_out_item),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .hit_o             (hit_o),
    .stream_out_o      (stream_out_o),
    .stream_accesses_o (stream_accesses_o),
    .stream_misses_o   (stream_misses_o),
    .evicted_now_o     (evicted_now_o),
    .home_entries_o    (home_entries_o),
    .home_used_bytes_o (home_used_bytes_o),
    .home_evictions_o  (home_evictions_o)
  );

endmodule

`default_nettype wire
